@@ hdl/lpshd_pkg.sv @@
// ============================================================================
// lpshd_pkg: shared definitions for the lens pixel shader
// Register indexes, mode flag bit positions, field widths and the screen
// size limit used by the shader datapath and its port checker.
// ============================================================================
package lpshd_pkg;

  // Largest screen dimension in pixels; larger register values are clamped.
  localparam logic [12:0] SCREEN_MAX = 13'd4096;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Field widths.
  localparam int POS_W    = 13;
  localparam int SIZE_W   = 13;
  localparam int LENS_W   = 8;
  localparam int OFFSET_W = 27;
  localparam int PIXEL_W  = 32;
  localparam int ADDR_W   = 26;
  localparam int FLAGS_W  = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X      = 3'd0,
    REG_POS_Y      = 3'd1,
    REG_WIDTH      = 3'd2,
    REG_HEIGHT     = 3'd3,
    REG_LENS_TINT  = 3'd4,
    REG_RIM_TINT   = 3'd5,
    REG_MODE_FLAGS = 3'd6
  } cfg_reg_t;

  // Bit positions inside mode_flags.
  localparam int FLAG_VISIBLE  = 0;
  localparam int FLAG_TINT     = 1;
  localparam int FLAG_COMP     = 2;
  localparam int FLAG_RIM_TINT = 3;
  localparam int FLAG_RIM_COMP = 4;

endpackage

@@ hdl/lens_pixel_shade.sv @@
// ============================================================================
// lens_pixel_shade: per-pixel shading for a screen lens
// Picks the displaced or the direct source pixel, applies the lens or outline
// tint blend and complement, and computes the destination byte address.
// ============================================================================
//
//  Channel | Ports                                     | Handshake
//  --------+-------------------------------------------+---------------------------
//  input   | start, busy, in_*                         | taken when start && !busy
//  result  | out_strobe, out_dest_address, out_pixel   | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_data               | written when cfg_we is high
//
// One transaction is accepted every clock; busy is always low.
// A result passes the input register, which the accepting edge loads, then three
// datapath stages (position and products, source select, blend products) and
// the result register that holds the final color and drives the result ports.
// Hidden lenses and clipped pixels travel the pipeline and produce no strobe.
// Reset (rst_n low at a clock edge) empties the pipeline and restores the
// configuration registers; the result side cannot stall the block.

module lens_pixel_shade (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                start,
  output logic                                busy,
  input  logic [lpshd_pkg::LENS_W-1:0]        in_lens_x,
  input  logic [lpshd_pkg::LENS_W-1:0]        in_lens_y,
  input  logic signed [lpshd_pkg::OFFSET_W-1:0] in_map_offset,
  input  logic                                in_mask,
  input  logic                                in_on_rim,
  input  logic [lpshd_pkg::PIXEL_W-1:0]       in_displaced_pixel,
  input  logic [lpshd_pkg::PIXEL_W-1:0]       in_direct_pixel,
  // Result channel
  output logic                                out_strobe,
  output logic [lpshd_pkg::ADDR_W-1:0]        out_dest_address,
  output logic [lpshd_pkg::PIXEL_W-1:0]       out_pixel,
  // Configuration port
  input  logic                                cfg_we,
  input  logic [lpshd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpshd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import lpshd_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0] pos_y_r, pos_y_nxt;
  logic [SIZE_W-1:0]       width_r, width_nxt;
  logic [SIZE_W-1:0]       height_r, height_nxt;
  logic [PIXEL_W-1:0]      lens_tint_r, lens_tint_nxt;
  logic [PIXEL_W-1:0]      rim_tint_r, rim_tint_nxt;
  logic [FLAGS_W-1:0]      flags_r, flags_nxt;

  // Decode a register write.
  always_comb begin
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    lens_tint_nxt = lens_tint_r;
    rim_tint_nxt  = rim_tint_r;
    flags_nxt     = flags_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_POS_X:      pos_x_nxt     = $signed(cfg_data[POS_W-1:0]);
        REG_POS_Y:      pos_y_nxt     = $signed(cfg_data[POS_W-1:0]);
        REG_WIDTH:      width_nxt     = cfg_data[SIZE_W-1:0];
        REG_HEIGHT:     height_nxt    = cfg_data[SIZE_W-1:0];
        REG_LENS_TINT:  lens_tint_nxt = cfg_data[PIXEL_W-1:0];
        REG_RIM_TINT:   rim_tint_nxt  = cfg_data[PIXEL_W-1:0];
        REG_MODE_FLAGS: flags_nxt     = cfg_data[FLAGS_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      width_r     <= SCREEN_MAX;
      height_r    <= SCREEN_MAX;
      lens_tint_r <= '0;
      rim_tint_r  <= '0;
      flags_r     <= '0;
    end else begin
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      lens_tint_r <= lens_tint_nxt;
      rim_tint_r  <= rim_tint_nxt;
      flags_r     <= flags_nxt;
    end
  end

  // Effective screen size, clamped to the supported maximum.
  logic [SIZE_W-1:0] scr_w;
  logic [SIZE_W-1:0] scr_h;
  assign scr_w = (width_r  > SCREEN_MAX) ? SCREEN_MAX : width_r;
  assign scr_h = (height_r > SCREEN_MAX) ? SCREEN_MAX : height_r;

  // The block never holds off a transaction.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  logic                       s0_valid_r;
  logic [LENS_W-1:0]          s0_lens_x_r;
  logic [LENS_W-1:0]          s0_lens_y_r;
  logic signed [OFFSET_W-1:0] s0_offset_r;
  logic                       s0_mask_r;
  logic                       s0_rim_r;
  logic [PIXEL_W-1:0]         s0_disp_r;
  logic [PIXEL_W-1:0]         s0_direct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_lens_x_r <= in_lens_x;
    s0_lens_y_r <= in_lens_y;
    s0_offset_r <= in_map_offset;
    s0_mask_r   <= in_mask;
    s0_rim_r    <= in_on_rim;
    s0_disp_r   <= in_displaced_pixel;
    s0_direct_r <= in_direct_pixel;
  end

  // --------------------------------------------------------------------------
  // Stage 1: screen position, clipping and the three products
  // --------------------------------------------------------------------------
  logic signed [POS_W:0]   sx;
  logic signed [POS_W:0]   sy;
  logic                    s1_keep_nxt;
  logic [24:0]             s1_row_nxt;   // sy * w for an on-screen row
  logic signed [26:0]      s1_pyw_nxt;   // lens_pos_y * w
  logic [25:0]             s1_maxp_nxt;  // w * (h - 1)
  logic [SIZE_W-1:0]       h_m1;

  always_comb begin
    sx = $signed({6'b0, s0_lens_x_r}) + $signed({pos_x_r[POS_W-1], pos_x_r});
    sy = $signed({6'b0, s0_lens_y_r}) + $signed({pos_y_r[POS_W-1], pos_y_r});
    // A pixel survives only when visible and inside the screen on both axes.
    s1_keep_nxt = s0_valid_r && flags_r[FLAG_VISIBLE]
                  && !sx[POS_W] && (sx[POS_W-1:0] < scr_w)
                  && !sy[POS_W] && (sy[POS_W-1:0] < scr_h);
    s1_row_nxt  = 25'(sy[11:0]) * 25'(scr_w);
    s1_pyw_nxt  = 27'(pos_y_r) * 27'($signed({1'b0, scr_w}));
    h_m1        = scr_h - 13'd1;
    s1_maxp_nxt = 26'(scr_w) * 26'(h_m1);
  end

  logic                       s1_valid_r;
  logic [11:0]                s1_sx_r;
  logic [24:0]                s1_row_r;
  logic signed [26:0]         s1_pyw_r;
  logic [25:0]                s1_maxp_r;
  logic signed [OFFSET_W-1:0] s1_offset_r;
  logic                       s1_mask_r;
  logic                       s1_rim_r;
  logic [PIXEL_W-1:0]         s1_disp_r;
  logic [PIXEL_W-1:0]         s1_direct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_sx_r     <= sx[11:0];
    s1_row_r    <= s1_row_nxt;
    s1_pyw_r    <= s1_pyw_nxt;
    s1_maxp_r   <= s1_maxp_nxt;
    s1_offset_r <= s0_offset_r;
    s1_mask_r   <= s0_mask_r;
    s1_rim_r    <= s0_rim_r;
    s1_disp_r   <= s0_disp_r;
    s1_direct_r <= s0_direct_r;
  end

  // --------------------------------------------------------------------------
  // Stage 2: displaced address check, source select, shading choice
  // --------------------------------------------------------------------------
  logic signed [26:0]      corner;
  logic signed [29:0]      disp_addr;
  logic signed [29:0]      max_addr;
  logic [24:0]             lin_pos;
  logic [ADDR_W-1:0]       s2_addr_nxt;
  logic [PIXEL_W-1:0]      s2_px_nxt;
  logic [PIXEL_W-1:0]      s2_tint_nxt;
  logic                    s2_blend_nxt;
  logic                    s2_comp_nxt;
  logic                    rim_path;

  always_comb begin
    corner    = s1_pyw_r + 27'(pos_x_r);
    disp_addr = 30'(s1_offset_r) + $signed({corner[26], corner, 2'b00});
    max_addr  = $signed({2'b00, s1_maxp_r, 2'b00});
    s2_px_nxt = ((disp_addr > 30'sd0) && (disp_addr < max_addr)) ? s1_disp_r : s1_direct_r;

    lin_pos     = s1_row_r + 25'(s1_sx_r);
    s2_addr_nxt = {lin_pos[ADDR_W-3:0], 2'b00};

    // Outline shading takes priority over the lens body when enabled.
    rim_path = (flags_r[FLAG_RIM_TINT] || flags_r[FLAG_RIM_COMP]) && s1_rim_r;
    if (rim_path) begin
      s2_tint_nxt  = rim_tint_r;
      s2_blend_nxt = flags_r[FLAG_RIM_TINT];
      s2_comp_nxt  = flags_r[FLAG_RIM_COMP];
    end else begin
      s2_tint_nxt  = lens_tint_r;
      s2_blend_nxt = s1_mask_r && flags_r[FLAG_TINT];
      s2_comp_nxt  = s1_mask_r && flags_r[FLAG_COMP];
    end
  end

  logic                    s2_valid_r;
  logic [ADDR_W-1:0]       s2_addr_r;
  logic [PIXEL_W-1:0]      s2_px_r;
  logic [PIXEL_W-1:0]      s2_tint_r;
  logic                    s2_blend_r;
  logic                    s2_comp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r  <= s2_addr_nxt;
    s2_px_r    <= s2_px_nxt;
    s2_tint_r  <= s2_tint_nxt;
    s2_blend_r <= s2_blend_nxt;
    s2_comp_r  <= s2_comp_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 3: blend products p*(255-a) + t*a for each color byte
  // --------------------------------------------------------------------------
  logic [7:0]  alpha;
  logic [7:0]  inv_alpha;
  logic [15:0] s3_mix_nxt [3];

  always_comb begin
    alpha     = s2_tint_r[31:24];
    inv_alpha = 8'd255 - alpha;
    for (int k = 0; k < 3; k++) begin
      s3_mix_nxt[k] = 16'(s2_px_r[8*k +: 8]) * 16'(inv_alpha)
                    + 16'(s2_tint_r[8*k +: 8]) * 16'(alpha);
    end
  end

  logic                    s3_valid_r;
  logic [ADDR_W-1:0]       s3_addr_r;
  logic [PIXEL_W-1:0]      s3_px_r;
  logic [15:0]             s3_mix_r [3];
  logic                    s3_blend_r;
  logic                    s3_comp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_addr_r  <= s2_addr_r;
    s3_px_r    <= s2_px_r;
    s3_mix_r   <= s3_mix_nxt;
    s3_blend_r <= s2_blend_r;
    s3_comp_r  <= s2_comp_r;
  end

  // --------------------------------------------------------------------------
  // Stage 4: divide by 255, complement, result register
  // --------------------------------------------------------------------------
  // For x <= 65025, floor(x/255) equals (x + 1 + (x >> 8)) >> 8.
  logic [16:0]        quot [3];
  logic [PIXEL_W-1:0] color_nxt;

  always_comb begin
    color_nxt = s3_px_r;
    for (int k = 0; k < 3; k++) begin
      quot[k] = 17'(s3_mix_r[k]) + 17'd1 + 17'(s3_mix_r[k][15:8]);
      if (s3_blend_r) begin
        color_nxt[8*k +: 8] = quot[k][15:8];
      end
    end
    if (s3_comp_r) begin
      color_nxt[23:0] = ~color_nxt[23:0];
    end
  end

  logic                    out_strobe_r;
  logic [ADDR_W-1:0]       out_addr_r;
  logic [PIXEL_W-1:0]      out_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r  <= s3_addr_r;
    out_pixel_r <= color_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_dest_address = out_addr_r;
  assign out_pixel        = out_pixel_r;

endmodule

@@ hdl/lpshd_check.sv @@
// ============================================================================
// lpshd_check: port-level checks for the lens pixel shader
// Watches the top-level ports for busy, latency, alignment and alpha pass-through.
// ============================================================================
module lpshd_check (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [lpshd_pkg::PIXEL_W-1:0]      in_displaced_pixel,
  input  logic [lpshd_pkg::PIXEL_W-1:0]      in_direct_pixel,
  input  logic                               out_strobe,
  input  logic [lpshd_pkg::ADDR_W-1:0]       out_dest_address,
  input  logic [lpshd_pkg::PIXEL_W-1:0]      out_pixel
);

  import lpshd_pkg::*;

  // The shader never stalls its source.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised by the shader");

  // Every result comes from an accepted input transaction.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 5))
    else $error("result without a matching input transaction");

  // Destination addresses are whole pixels.
  a_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_dest_address[1:0] == 2'b00))
    else $error("destination address not pixel aligned");

  // Alpha passes through from whichever source was chosen; checked when both sources carry the same alpha.
  a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_displaced_pixel[31:24] == in_direct_pixel[31:24], 5))
    |-> (out_pixel[31:24] == $past(in_direct_pixel[31:24], 5)))
    else $error("alpha byte changed by shading");

endmodule

bind lens_pixel_shade lpshd_check u_lpshd_check (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_displaced_pixel (in_displaced_pixel),
  .in_direct_pixel    (in_direct_pixel),
  .out_strobe         (out_strobe),
  .out_dest_address   (out_dest_address),
  .out_pixel          (out_pixel)
);
